// ===== rtl/gcme_pkg.sv =====
// ----------------------------------------------------------------------------
// gcme_pkg
// Shared constants, mode codes and helper functions for the GOST 28147-89
// mode engine: substitution table, round function and byte masking.
// ----------------------------------------------------------------------------
package gcme_pkg;

    localparam int BLOCK_W   = 64;
    localparam int HALF_W    = 32;
    localparam int CNT_W     = 4;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int ROUND_W   = 5;
    localparam int KEY_REGS  = 4;
    localparam int ROT_LEFT  = 11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_45 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_67 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IV     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd5;

    // cipher mode codes
    localparam logic [MODE_W-1:0] MODE_ECB_ENC = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ECB_DEC = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GAMMA   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CFB_ENC = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CFB_DEC = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MAC     = 3'd5;

    localparam logic [CNT_W-1:0]   FULL_BYTES   = 4'd8;
    localparam logic [ROUND_W-1:0] LAST_CIPHER  = 5'd31;
    localparam logic [ROUND_W-1:0] LAST_MAC     = 5'd15;
    localparam logic [ROUND_W-1:0] FIRST_REV_ENC = 5'd24;
    localparam logic [ROUND_W-1:0] FIRST_REV_DEC = 5'd8;

    typedef logic [3:0] nibble_t;
    typedef nibble_t sbox_row_t [16];

    localparam sbox_row_t SBOX [8] = '{
        '{4'd4,  4'd10, 4'd9,  4'd2,  4'd13, 4'd8,  4'd0,  4'd14,
          4'd6,  4'd11, 4'd1,  4'd12, 4'd7,  4'd15, 4'd5,  4'd3},
        '{4'd14, 4'd11, 4'd4,  4'd12, 4'd6,  4'd13, 4'd15, 4'd10,
          4'd2,  4'd3,  4'd8,  4'd1,  4'd0,  4'd7,  4'd5,  4'd9},
        '{4'd5,  4'd8,  4'd1,  4'd13, 4'd10, 4'd3,  4'd4,  4'd2,
          4'd14, 4'd15, 4'd12, 4'd7,  4'd6,  4'd0,  4'd9,  4'd11},
        '{4'd7,  4'd13, 4'd10, 4'd1,  4'd0,  4'd8,  4'd9,  4'd15,
          4'd14, 4'd4,  4'd6,  4'd12, 4'd11, 4'd2,  4'd5,  4'd3},
        '{4'd6,  4'd12, 4'd7,  4'd1,  4'd5,  4'd15, 4'd13, 4'd8,
          4'd4,  4'd10, 4'd9,  4'd14, 4'd0,  4'd3,  4'd11, 4'd2},
        '{4'd4,  4'd11, 4'd10, 4'd0,  4'd7,  4'd2,  4'd1,  4'd13,
          4'd3,  4'd6,  4'd8,  4'd5,  4'd9,  4'd12, 4'd15, 4'd14},
        '{4'd13, 4'd11, 4'd4,  4'd1,  4'd3,  4'd15, 4'd5,  4'd9,
          4'd0,  4'd10, 4'd14, 4'd7,  4'd6,  4'd8,  4'd2,  4'd12},
        '{4'd1,  4'd15, 4'd13, 4'd0,  4'd5,  4'd7,  4'd10, 4'd4,
          4'd9,  4'd2,  4'd3,  4'd14, 4'd6,  4'd11, 4'd8,  4'd12}
    };

    // one feistel round function: add key, substitute, rotate left by 11
    function automatic logic [HALF_W-1:0] round_fn(input logic [HALF_W-1:0] half,
                                                  input logic [HALF_W-1:0] kw);
        logic [HALF_W-1:0] sum;
        logic [HALF_W-1:0] sub;
        sum = half + kw;
        sub = '0;
        for (int i = 0; i < 8; i++) begin
            sub[4*i +: 4] = SBOX[i][sum[4*i +: 4]];
        end
        return {sub[HALF_W-ROT_LEFT-1:0], sub[HALF_W-1:HALF_W-ROT_LEFT]};
    endfunction

    // out of range counts read as a full block
    function automatic logic [CNT_W-1:0] norm_count(input logic [CNT_W-1:0] vb);
        if (vb == '0 || vb > FULL_BYTES) begin
            return FULL_BYTES;
        end
        return vb;
    endfunction

    // byte mask for a count of 1..8
    function automatic logic [BLOCK_W-1:0] byte_mask(input logic [CNT_W-1:0] vb);
        logic [BLOCK_W-1:0] m;
        for (int i = 0; i < 8; i++) begin
            m[8*i +: 8] = (CNT_W'(i) < vb) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

// ===== rtl/gost_cipher_mode_engine_core.sv =====
// ----------------------------------------------------------------------------
// gost_cipher_mode_engine_core
// GOST 28147-89 block engine with ECB, counter gamming, CFB and MAC modes.
// ----------------------------------------------------------------------------
// One shared round unit runs one Feistel round per clock. A request is
// loaded into the round halves at its acceptance edge and reaches the result
// register after 32 rounds and a finish step in ECB, gamming and CFB modes,
// after 16 rounds and the finish step in MAC mode, and after the finish step
// alone for an unused mode code. The finish step repeats while the output
// register still holds an untaken result. The input side is ready only while
// the sequencer is idle, from the cycle after the finish, so no new request
// is taken until the last one has finished; a finished result sits in the
// output register and the next request may be taken while it waits. The
// chain register carries the counter, CFB feedback or running MAC between
// requests; first_block reloads it from the IV (for MAC, zero stands in for
// it). Configuration is written through a plain write port; the user must
// write it only while the block idles, which the block does not enforce.
module gost_cipher_mode_engine_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_write_en,
    input  logic [gcme_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gcme_pkg::BLOCK_W-1:0]    cfg_wdata,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [gcme_pkg::BLOCK_W-1:0]    s_data_block,
    input  logic [gcme_pkg::CNT_W-1:0]      s_valid_bytes,
    input  logic                            s_first_block,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gcme_pkg::BLOCK_W-1:0]    m_out_block,
    output logic [gcme_pkg::CNT_W-1:0]      m_out_bytes
);
    import gcme_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // configuration registers
    logic [BLOCK_W-1:0] key_reg [KEY_REGS];
    logic [BLOCK_W-1:0] iv_reg;
    logic [MODE_W-1:0]  mode_reg;

    // sequencer and datapath registers
    logic [1:0]         state_reg, state_next;
    logic [ROUND_W-1:0] rnd_reg, rnd_next;
    logic [HALF_W-1:0]  n1_reg, n1_next;
    logic [HALF_W-1:0]  n2_reg, n2_next;
    logic [BLOCK_W-1:0] chain_reg, chain_next;
    logic [BLOCK_W-1:0] data_reg, data_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               m_valid_reg, m_valid_next;
    logic [BLOCK_W-1:0] out_block_reg, out_block_next;
    logic [CNT_W-1:0]   out_bytes_reg, out_bytes_next;

    logic               s_accept;
    logic               out_free;
    logic [CNT_W-1:0]   in_cnt;
    logic [BLOCK_W-1:0] in_data;
    logic [BLOCK_W-1:0] start_chain;
    logic [BLOCK_W-1:0] start_block;
    logic               is_mac;
    logic               is_dec;
    logic               last_rnd;
    logic [2:0]         key_idx;
    logic [HALF_W-1:0]  key_word;
    logic [HALF_W-1:0]  round_out;
    logic [BLOCK_W-1:0] fin_block;
    logic [BLOCK_W-1:0] fin_mask;

    assign s_ready     = (state_reg == ST_IDLE);
    assign s_accept    = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_out_block = out_block_reg;
    assign m_out_bytes = out_bytes_reg;
    assign out_free    = !m_valid_reg || m_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_REGS; i++) begin
                key_reg[i] <= '0;
            end
            iv_reg   <= '0;
            mode_reg <= MODE_ECB_ENC;
        end else if (cfg_write_en) begin
            case (cfg_index)
                REG_KEY_01: key_reg[0] <= cfg_wdata;
                REG_KEY_23: key_reg[1] <= cfg_wdata;
                REG_KEY_45: key_reg[2] <= cfg_wdata;
                REG_KEY_67: key_reg[3] <= cfg_wdata;
                REG_IV:     iv_reg     <= cfg_wdata;
                REG_MODE:   mode_reg   <= cfg_wdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // input masking and starting block
    assign in_cnt  = norm_count(s_valid_bytes);
    assign in_data = s_data_block & byte_mask(in_cnt);

    always_comb begin
        start_chain = (s_first_block) ? iv_reg : chain_reg;
        start_block = in_data;
        case (mode_reg)
            MODE_GAMMA, MODE_CFB_ENC, MODE_CFB_DEC: start_block = start_chain;
            MODE_MAC: start_block = ((s_first_block) ? '0 : chain_reg) ^ in_data;
            default: start_block = in_data;
        endcase
    end

    // key schedule position for the current round
    assign is_mac = (mode_reg == MODE_MAC);
    assign is_dec = (mode_reg == MODE_ECB_DEC);

    always_comb begin
        if (is_mac) begin
            key_idx = rnd_reg[2:0];
        end else if (is_dec) begin
            key_idx = (rnd_reg < FIRST_REV_DEC) ? rnd_reg[2:0] : ~rnd_reg[2:0];
        end else begin
            key_idx = (rnd_reg < FIRST_REV_ENC) ? rnd_reg[2:0] : ~rnd_reg[2:0];
        end
    end

    assign key_word  = key_idx[0] ? key_reg[key_idx[2:1]][BLOCK_W-1:HALF_W]
                                  : key_reg[key_idx[2:1]][HALF_W-1:0];
    assign last_rnd  = is_mac ? (rnd_reg == LAST_MAC) : (rnd_reg == LAST_CIPHER);

    // shared round unit
    assign round_out = n2_reg ^ round_fn(n1_reg, key_word);

    assign fin_block = {n2_reg, n1_reg};
    assign fin_mask  = byte_mask(cnt_reg);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        rnd_next       = rnd_reg;
        n1_next        = n1_reg;
        n2_next        = n2_reg;
        chain_next     = chain_reg;
        data_next      = data_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg;
        out_block_next = out_block_reg;
        out_bytes_next = out_bytes_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    data_next = in_data;
                    cnt_next  = in_cnt;
                    n1_next   = start_block[HALF_W-1:0];
                    n2_next   = start_block[BLOCK_W-1:HALF_W];
                    rnd_next  = '0;
                    if (mode_reg == MODE_GAMMA || mode_reg == MODE_CFB_ENC ||
                        mode_reg == MODE_CFB_DEC) begin
                        chain_next = start_chain;
                    end
                    if (mode_reg > MODE_MAC) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (last_rnd && !is_mac) begin
                    n2_next = round_out;
                end else begin
                    n2_next = n1_reg;
                    n1_next = round_out;
                end
                rnd_next = rnd_reg + 1'b1;
                if (last_rnd) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_bytes_next = cnt_reg;
                    state_next     = ST_IDLE;
                    case (mode_reg)
                        MODE_ECB_ENC, MODE_ECB_DEC: begin
                            out_block_next = fin_block;
                            out_bytes_next = FULL_BYTES;
                        end
                        MODE_GAMMA: begin
                            out_block_next = (data_reg ^ fin_block) & fin_mask;
                            chain_next     = chain_reg + 1'b1;
                        end
                        MODE_CFB_ENC: begin
                            out_block_next = (data_reg ^ fin_block) & fin_mask;
                            chain_next     = data_reg ^ fin_block;
                        end
                        MODE_CFB_DEC: begin
                            out_block_next = (data_reg ^ fin_block) & fin_mask;
                            chain_next     = data_reg;
                        end
                        MODE_MAC: begin
                            out_block_next = fin_block;
                            out_bytes_next = FULL_BYTES;
                            chain_next     = fin_block;
                        end
                        default: begin
                            out_block_next = data_reg;
                            out_bytes_next = FULL_BYTES;
                        end
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rnd_reg     <= '0;
            chain_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rnd_reg     <= rnd_next;
            chain_reg   <= chain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        n1_reg        <= n1_next;
        n2_reg        <= n2_next;
        data_reg      <= data_next;
        cnt_reg       <= cnt_next;
        out_block_reg <= out_block_next;
        out_bytes_reg <= out_bytes_next;
    end

`ifndef ASSERT_OFF
    // a valid mode request enters the round loop
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && mode_reg <= MODE_MAC) |=> (state_reg == ST_RUN))
        else $error("request did not start the round loop");

    // the last round always hands over to the finish step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && last_rnd) |=> (state_reg == ST_FIN))
        else $error("round loop did not finish");

    // finish with a free output register produces a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && !m_valid_reg) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("finish step did not deliver a result");

    // first gamming block reloads the counter from the iv
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_first_block && mode_reg == MODE_GAMMA) |=>
            (chain_reg == $past(iv_reg)))
        else $error("counter not reloaded from iv");

    // in MAC mode the round counter never runs past the MAC length while running
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && is_mac) |-> (rnd_reg <= LAST_MAC))
        else $error("mac round count overrun");
`endif

endmodule
